// ===== design/i2dc_pkg.sv =====
// ----------------------------------------------------------------------------
// i2dc_pkg: shared types and constants
// Constants, controller state, command and status types and the decimal
// adjust-and-shift step used by the integer to decimal text converter.
// ----------------------------------------------------------------------------
package i2dc_pkg;

  localparam int unsigned MagW        = 64;
  localparam int unsigned NumDigits   = 20;
  localparam int unsigned BcdW        = NumDigits * 4;
  localparam int unsigned BitsPerStep = 2;
  localparam int unsigned NumSteps    = MagW / BitsPerStep;
  localparam int unsigned StepW       = $clog2(NumSteps);
  localparam int unsigned DigW        = $clog2(NumDigits + 1);

  localparam logic [7:0] CodeZero  = 8'd48;
  localparam logic [7:0] CodeMinus = 8'd45;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CONV = 5'b00010,
    S_SKIP = 5'b00100,
    S_SIGN = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  typedef struct packed {
    logic load;
    logic conv;
    logic skip;
    logic sign;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic conv_last;
    logic top_zero;
    logic one_left;
    logic neg;
    logic out_free;
  } status_t;

  // One shift-and-add-3 step: correct every BCD digit, then shift in one bit.
  function automatic logic [BcdW-1:0] dd_step(input logic [BcdW-1:0] bcd, input logic bit_in);
    logic [BcdW-1:0] adj;
    logic [3:0]      dig;
    adj = bcd;
    for (int i = 0; i < NumDigits; i++) begin
      dig = bcd[i*4 +: 4];
      if (dig >= 4'd5) begin
        adj[i*4 +: 4] = dig + 4'd3;
      end
    end
    return {adj[BcdW-2:0], bit_in};
  endfunction

endpackage

// ===== design/i2dc_if.sv =====
// ----------------------------------------------------------------------------
// i2dc interfaces: input and output channels
// Valid/ready channels that carry one number in and one character out.
// ----------------------------------------------------------------------------
interface i2dc_in_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] number;

  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

interface i2dc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

// ===== design/int64_to_decimal_chars.sv =====
// Operation: a number is taken in, converted to BCD two bits per cycle by the
// shift-and-add-3 loop, then leading zeros are dropped one digit per cycle and
// the characters leave one per cycle while the output is not stalled.
// A new number is accepted only after the last character of the previous
// number has been loaded into the output register.
// Reset clears the controller and the output valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
// int64_to_decimal_chars: signed 64-bit integer to decimal ASCII text
// Accepts one signed number per transaction and emits its decimal text, one
// character per output transaction, with the final character marked.
// ----------------------------------------------------------------------------
module int64_to_decimal_chars import i2dc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2dc_in_if.sink     in_i,
  i2dc_out_if.source  out_o
);

  cmd_t    cmd;
  status_t status;

  i2dc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  i2dc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .number_i    (in_i.number),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .char_code_o (out_o.char_code),
    .last_char_o (out_o.last_char)
  );

`ifndef SYNTH
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("Input accepted again while a conversion was in progress.");

  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.char_code == CodeMinus && !out_o.last_char) ||
                    (out_o.char_code >= CodeZero && out_o.char_code <= CodeZero + 8'd9))
    else $error("Output character is neither a minus sign nor a digit.");

  a_cmd_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.conv, cmd.skip, cmd.sign, cmd.emit}))
    else $error("Controller issued more than one datapath command.");
`endif

endmodule

// ===== design/i2dc_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2dc_ctrl: conversion sequencer
// Steps through accept, binary to BCD conversion, leading zero removal,
// sign output and digit output, issuing one command set per cycle.
// ----------------------------------------------------------------------------
module i2dc_ctrl import i2dc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CONV;
        end
      end
      S_CONV: begin
        cmd_o.conv = 1'b1;
        if (status_i.conv_last) begin
          state_d = S_SKIP;
        end
      end
      S_SKIP: begin
        if (status_i.top_zero && !status_i.one_left) begin
          cmd_o.skip = 1'b1;
        end else if (status_i.neg) begin
          state_d = S_SIGN;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_SIGN: begin
        if (status_i.out_free) begin
          cmd_o.sign = 1'b1;
          state_d    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.one_left) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/i2dc_dp.sv =====
// ----------------------------------------------------------------------------
// i2dc_dp: conversion datapath
// Holds the magnitude and its BCD image, performs two shift-and-add-3 steps
// per cycle and drives the registered character output.
// ----------------------------------------------------------------------------
module i2dc_dp import i2dc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [63:0] number_i,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [7:0]         char_code_o,
  output logic               last_char_o
);

  logic [MagW-1:0]  bin_q, bin_d;
  logic [BcdW-1:0]  bcd_q, bcd_d;
  logic [StepW-1:0] step_q, step_d;
  logic [DigW-1:0]  dig_q, dig_d;
  logic             neg_q, neg_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_char_q, out_char_d;
  logic             out_last_q, out_last_d;

  logic [MagW-1:0]  raw;
  logic [BcdW-1:0]  bcd_s1;
  logic [3:0]       top_dig;

  assign raw     = number_i;
  assign top_dig = bcd_q[BcdW-1 -: 4];
  assign bcd_s1  = dd_step(bcd_q, bin_q[MagW-1]);

  assign status_o.conv_last = (step_q == StepW'(NumSteps - 1));
  assign status_o.top_zero  = (top_dig == 4'd0);
  assign status_o.one_left  = (dig_q == DigW'(1));
  assign status_o.neg       = neg_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    step_d      = step_q;
    dig_d       = dig_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load) begin
      neg_d  = raw[MagW-1];
      bin_d  = raw[MagW-1] ? (~raw + MagW'(1)) : raw;
      bcd_d  = '0;
      step_d = '0;
      dig_d  = DigW'(NumDigits);
    end
    if (cmd_i.conv) begin
      bcd_d  = dd_step(bcd_s1, bin_q[MagW-2]);
      bin_d  = {bin_q[MagW-3:0], 2'b00};
      step_d = step_q + StepW'(1);
    end
    if (cmd_i.skip || cmd_i.emit) begin
      bcd_d = {bcd_q[BcdW-5:0], 4'd0};
      dig_d = dig_q - DigW'(1);
    end
    if (cmd_i.sign) begin
      out_valid_d = 1'b1;
      out_char_d  = CodeMinus;
      out_last_d  = 1'b0;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_char_d  = CodeZero + {4'd0, top_dig};
      out_last_d  = status_o.one_left;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= '0;
      dig_q       <= '0;
      neg_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      dig_q       <= dig_d;
      neg_q       <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q      <= bin_d;
    bcd_q      <= bcd_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = out_char_q;
  assign last_char_o = out_last_q;

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for int64_to_decimal_chars
// Sends signed 64-bit numbers through the input channel and checks every
// character that leaves the output channel against decimal text that the
// testbench works out itself. Corner values come first, then random numbers
// in four phases with different amounts of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [7:0] AsciiZero  = 8'd48;
  localparam logic [7:0] AsciiMinus = 8'd45;
  localparam int unsigned NumCorners = 24;
  localparam int unsigned NumPhases = 4;
  localparam int unsigned ItemsPerPhase = 35;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  class decimal_text_check;
    text_char_t  pending_chars[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function void note_number(logic signed [63:0] number);
      logic [63:0] mag;
      logic [63:0] rem;
      logic [7:0]  digits[$];
      text_char_t  c;
      mag = number;
      if (number[63]) begin
        mag = ~mag + 64'd1;
        c.code = AsciiMinus;
        c.last = 1'b0;
        pending_chars.push_back(c);
      end
      do begin
        rem = mag % 64'd10;
        digits.push_front(AsciiZero + rem[7:0]);
        mag = mag / 64'd10;
      end while (mag != 64'd0);
      foreach (digits[i]) begin
        c.code = digits[i];
        c.last = (i == digits.size() - 1);
        pending_chars.push_back(c);
      end
    endfunction

    function void check_char(logic [7:0] code, logic last);
      text_char_t want;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual code %0d last %0b",
                 $time, code, last);
        errors++;
      end else begin
        want = pending_chars.pop_front();
        if (code !== want.code || last !== want.last) begin
          $display("%0t: expected code %0d last %0b, actual code %0d last %0b",
                   $time, want.code, want.last, code, last);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  int unsigned idle_pct;
  int unsigned stall_pct;

  i2dc_in_if  in_if ();
  i2dc_out_if out_if ();

  decimal_text_check text_check = new();

  logic [63:0] corner_numbers [NumCorners] = '{
    64'd0, 64'd1, -64'd1, 64'd9, -64'd9, 64'd10, -64'd10, 64'd99, 64'd100, -64'd1000,
    64'd12345, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
    64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE, 64'd1000000000000000000,
    -64'd1000000000000000000, 64'd999999999999999999, -64'd999999999999999999,
    64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 64'hAAAA_AAAA_AAAA_AAAA,
    64'h5555_5555_5555_5555, 64'd4294967296
  };

  int64_to_decimal_chars dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic logic [63:0] random_number();
    logic [63:0] value;
    logic [63:0] power;
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(9);
    if (kind < 4) begin
      value = {$urandom, $urandom};
    end else if (kind < 8) begin
      n = $urandom_range(63, 1);
      value = {$urandom, $urandom} & ((64'd1 << n) - 64'd1);
      if ($urandom_range(1) == 1) begin
        value = ~value + 64'd1;
      end
    end else if (kind == 8) begin
      power = 64'd1;
      n = $urandom_range(18);
      repeat (n) power = power * 64'd10;
      value = power + $urandom_range(2) - 64'd1;
      if ($urandom_range(1) == 1) begin
        value = ~value + 64'd1;
      end
    end else if ($urandom_range(1) == 1) begin
      value = 64'h8000_0000_0000_0000 + $urandom_range(3);
    end else begin
      value = 64'h7FFF_FFFF_FFFF_FFFF - $urandom_range(3);
    end
    return value;
  endfunction

  task automatic send_number(input logic [63:0] number);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.number <= number;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    text_check.note_number(number);
  endtask

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid === 1'b1 && out_if.ready) begin
        text_check.check_char(out_if.char_code, out_if.last_char);
      end
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    in_if.valid  = 1'b0;
    in_if.number = '0;
    rst_ni       = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (corner_numbers[i]) begin
      send_number(corner_numbers[i]);
    end
    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 87;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 87;
        end
        default: begin
          idle_pct  = 30;
          stall_pct = 30;
        end
      endcase
      repeat (ItemsPerPhase) send_number(random_number());
    end
    in_if.valid <= 1'b0;
    while (text_check.pending_chars.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (text_check.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/i2dc_pkg.sv
design/i2dc_if.sv
design/i2dc_ctrl.sv
design/i2dc_dp.sv
design/int64_to_decimal_chars.sv
tb/sv/tb.sv
